// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the phase time editor RTL.
// No dependencies; include inside a module after the net type line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error(msg);

// Concurrent assertion on the module's clk and rst_n.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ----- rtl/spte_pkg.sv -----
// Shared types and constants of the phase time editor.
// No dependencies; compiled before every other RTL file.
`default_nettype none

package spte_pkg;

    // Phase codes
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_AMBER = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;
    localparam logic [1:0] PH_NONE  = 2'd3;

    // Button lock bit positions
    localparam int LOCK_W  = 4;
    localparam int LK_MODE = 0;
    localparam int LK_UP   = 1;
    localparam int LK_SET  = 2;
    localparam int LK_RST  = 3;

    // Times after reset
    localparam int RED_INIT   = 5;
    localparam int AMBER_INIT = 2;
    localparam int GREEN_INIT = 3;

    // Divide by five: (x * 205) >> 10 is exact for x below 1024
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    // Width of the time fields on the result channel
    localparam int OUT_VAL_W = 7;

    // Classified tick, front to back
    typedef struct packed {
        logic active;     // config mode after this tick
        logic leave;      // mode press ends config
        logic entry;      // tick enters config
        logic work;       // ordinary active tick
        logic up_press;
        logic set_press;
        logic rst_press;
        logic rst_long;
        logic refresh;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/spte_if.sv -----
// Channel interfaces of the phase time editor: tick input and result output.
// No dependencies.
`default_nettype none

interface spte_tick_if;
    logic valid;
    logic ready;
    logic enter_config;
    logic mode_button;
    logic up_button;
    logic set_button;
    logic reset_button;
    logic reset_held_long;

    modport source (
        output valid, enter_config, mode_button, up_button, set_button,
               reset_button, reset_held_long,
        input  ready
    );
    modport sink (
        input  valid, enter_config, mode_button, up_button, set_button,
               reset_button, reset_held_long,
        output ready
    );
endinterface

interface spte_result_if;
    logic       valid;
    logic       ready;
    logic       config_active;
    logic       leave_to_auto;
    logic [1:0] phase_edited;
    logic [6:0] edit_value;
    logic [6:0] red_time;
    logic [6:0] amber_time;
    logic [6:0] green_time;
    logic       display_refresh;
    logic       blink_phase;

    modport source (
        output valid, config_active, leave_to_auto, phase_edited, edit_value,
               red_time, amber_time, green_time, display_refresh, blink_phase,
        input  ready
    );
    modport sink (
        input  valid, config_active, leave_to_auto, phase_edited, edit_value,
               red_time, amber_time, green_time, display_refresh, blink_phase,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/spte_front.sv -----
// Front end: accepts ticks, tracks config mode, button locks and the refresh count.
// Depends on spte_pkg, spte_tick_if and assert_macros.svh.
`default_nettype none

module spte_front #(
    parameter int REFRESH_PERIOD = 5
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    spte_tick_if.sink       tick,
    output spte_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  wire logic       cmd_ready
);
    import spte_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(REFRESH_PERIOD + 1);

    logic              active_reg, active_next;
    logic [LOCK_W-1:0] lock_reg, lock_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LOCK_W-1:0] levels;
    logic              accept;

    // Pass the tick straight into the queue
    assign tick.ready = cmd_ready;
    assign cmd_valid  = tick.valid;
    assign accept     = tick.valid & cmd_ready;

    assign levels[LK_MODE] = tick.mode_button;
    assign levels[LK_UP]   = tick.up_button;
    assign levels[LK_SET]  = tick.set_button;
    assign levels[LK_RST]  = tick.reset_button;

    // Classify the tick
    always_comb
    begin
        active_next = active_reg;
        lock_next   = lock_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        if (!active_reg)
        begin
            if (tick.enter_config)
            begin
                active_next = 1'b1;
                lock_next   = levels;
                cmd.entry   = 1'b1;
            end
        end
        else if (tick.mode_button && !lock_reg[LK_MODE])
        begin
            lock_next[LK_MODE] = 1'b1;
            active_next        = 1'b0;
            cmd.leave          = 1'b1;
        end
        else
        begin
            cmd.work      = 1'b1;
            cmd.up_press  = tick.up_button & ~lock_reg[LK_UP];
            cmd.set_press = tick.set_button & ~lock_reg[LK_SET];
            cmd.rst_press = tick.reset_button & ~lock_reg[LK_RST];
            cmd.rst_long  = tick.reset_held_long;
            // a lock follows its button once it has been seen
            lock_next     = levels;
            if (cnt_reg == '0)
            begin
                cnt_next    = CNT_W'(REFRESH_PERIOD);
                cmd.refresh = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        cmd.active = active_next;
    end

    // Advance state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            lock_reg   <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            lock_reg   <= lock_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ASSERT_STD(a_entry_loads_locks, accept && cmd.entry |=> lock_reg == $past(levels),
        "entry did not load the button locks")
    `ASSERT_STD(a_leave_only_active, accept && cmd.leave |-> active_reg && !cmd.active,
        "mode press outside config mode")

endmodule

`default_nettype wire

// ----- rtl/spte_queue.sv -----
// Two-entry queue of classified ticks between front and back.
// Depends on spte_pkg and assert_macros.svh.
`default_nettype none

module spte_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire spte_pkg::cmd_t  push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output spte_pkg::cmd_t       pop_data
);
    import spte_pkg::*;
    `include "assert_macros.svh"

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = data_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    `ASSERT_STD(a_push_grows, push && !pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1),
        "queue count did not grow on push")

endmodule

`default_nettype wire

// ----- rtl/spte_back.sv -----
// Back end: edits phase times from classified ticks and registers the result.
// Depends on spte_pkg, spte_result_if and assert_macros.svh.
`default_nettype none

module spte_back #(
    parameter int MAX_VALUE = 99
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire spte_pkg::cmd_t  cmd,
    spte_result_if.source        result
);
    import spte_pkg::*;
    `include "assert_macros.svh"

    localparam int VAL_W  = $clog2(MAX_VALUE + 1);
    localparam int PROD_W = VAL_W + DIV5_SHIFT;
    localparam int EXT_W  = (VAL_W > OUT_VAL_W) ? VAL_W : OUT_VAL_W;

    logic [1:0]       phase_reg, phase_next;
    logic [VAL_W-1:0] edit_reg, edit_next;
    logic [VAL_W-1:0] red_reg, red_next;
    logic [VAL_W-1:0] amber_reg, amber_next;
    logic [VAL_W-1:0] green_reg, green_next;
    logic             blink_reg, blink_next;
    logic             out_valid_reg;
    logic             take;

    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  red_fifth;
    logic [VAL_W-1:0]  bal_amber, bal_green;
    logic [EXT_W-1:0]  edit_x, red_x, amber_x, green_x;

    assign cmd_ready    = !out_valid_reg || result.ready;
    assign take         = cmd_valid & cmd_ready;
    assign result.valid = out_valid_reg;

    // Rebalance amber and green from the stored red time
    assign prod      = PROD_W'(red_reg) * PROD_W'(DIV5_MUL);
    assign red_fifth = prod[DIV5_SHIFT +: VAL_W];
    always_comb
    begin
        if (red_reg < VAL_W'(2))
        begin
            bal_amber = '0;
            bal_green = VAL_W'(1);
        end
        else
        begin
            bal_amber = (red_fifth == '0) ? VAL_W'(1) : red_fifth;
            bal_green = red_reg - bal_amber;
        end
    end

    // Apply one tick: entry, leave, up, set, short reset, long reset, refresh
    always_comb
    begin
        phase_next = phase_reg;
        edit_next  = edit_reg;
        red_next   = red_reg;
        amber_next = amber_reg;
        green_next = green_reg;
        blink_next = blink_reg;
        if (cmd.entry)
        begin
            phase_next = PH_RED;
            edit_next  = red_reg;
        end
        if (cmd.leave)
        begin
            amber_next = bal_amber;
            green_next = bal_green;
        end
        if (cmd.work)
        begin
            if (cmd.up_press)
            begin
                edit_next = (edit_next >= VAL_W'(MAX_VALUE)) ? '0 : edit_next + VAL_W'(1);
            end
            if (cmd.set_press)
            begin
                case (phase_next)
                    PH_RED:
                    begin
                        red_next   = edit_next;
                        edit_next  = amber_reg;
                        phase_next = PH_AMBER;
                    end
                    PH_AMBER:
                    begin
                        amber_next = edit_next;
                        edit_next  = green_reg;
                        phase_next = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        amber_next = bal_amber;
                        green_next = bal_green;
                        edit_next  = red_reg;
                        phase_next = PH_RED;
                    end
                    default:
                    begin
                        phase_next = phase_next;
                    end
                endcase
            end
            if (cmd.rst_press)
            begin
                case (phase_next)
                    PH_RED:   edit_next = red_next;
                    PH_AMBER: edit_next = amber_next;
                    PH_GREEN: edit_next = green_next;
                    default:  edit_next = edit_next;
                endcase
            end
            if (cmd.rst_long)
            begin
                phase_next = PH_RED;
                edit_next  = red_next;
            end
            if (cmd.refresh)
            begin
                if (phase_next == PH_NONE)
                begin
                    phase_next = PH_RED;
                end
                else
                begin
                    blink_next = ~blink_reg;
                end
            end
        end
    end

    assign edit_x  = EXT_W'(edit_next);
    assign red_x   = EXT_W'(red_next);
    assign amber_x = EXT_W'(amber_next);
    assign green_x = EXT_W'(green_next);

    // Advance editor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RED;
            edit_reg  <= '0;
            red_reg   <= VAL_W'(RED_INIT);
            amber_reg <= VAL_W'(AMBER_INIT);
            green_reg <= VAL_W'(GREEN_INIT);
            blink_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            edit_reg  <= edit_next;
            red_reg   <= red_next;
            amber_reg <= amber_next;
            green_reg <= green_next;
            blink_reg <= blink_next;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result.config_active   <= cmd.active;
            result.leave_to_auto   <= cmd.leave;
            result.phase_edited    <= phase_next;
            result.edit_value      <= edit_x[OUT_VAL_W-1:0];
            result.red_time        <= red_x[OUT_VAL_W-1:0];
            result.amber_time      <= amber_x[OUT_VAL_W-1:0];
            result.green_time      <= green_x[OUT_VAL_W-1:0];
            result.display_refresh <= cmd.refresh;
            result.blink_phase     <= blink_next;
        end
    end

    `ASSERT_STD(a_phase_reachable, phase_reg != PH_NONE, "unreachable phase code")
    `ASSERT_STD(a_leave_ends_config,
        result.valid && result.leave_to_auto |-> !result.config_active,
        "leave reported while still in config mode")

endmodule

`default_nettype wire

// ----- rtl/signal_phase_time_editor.sv -----
// Phase time editor for a traffic light controller, one transfer per tick; a tick
// is accepted in every clock cycle while the queue has room. The front end
// classifies button presses against per-button locks and counts refresh ticks, a
// two-entry queue carries the classified ticks, and the back end applies them to
// the phase times (one combinational multiply-by-reciprocal for red/5) and holds
// the result in an output register, fed from a queue entry; the queue lets input and
// output stall independently. Depends on spte_pkg, spte_if and the spte_* modules.
`default_nettype none

module signal_phase_time_editor #(
    parameter int REFRESH_PERIOD = 5,
    parameter int MAX_VALUE      = 99
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    spte_tick_if.sink      tick,
    spte_result_if.source  result
);
    import spte_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    spte_front #(
        .REFRESH_PERIOD (REFRESH_PERIOD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    spte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    spte_back #(
        .MAX_VALUE (MAX_VALUE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .result    (result)
    );

endmodule

`default_nettype wire
